[rtl/hat_pkg.sv]
// Package: shared types and codes for the heap allocation tracker.
package hat_pkg;

   // Index and count widths cover the largest supported table (1024 records).
   localparam int IDX_W = 10;
   localparam int CNT_W = 11;

   typedef logic [IDX_W-1:0] idx_type;
   typedef logic [CNT_W-1:0] cnt_type;

   typedef enum logic [1:0] {
      OP_ALLOC   = 2'd0,
      OP_REALLOC = 2'd1,
      OP_FREE    = 2'd2,
      OP_NONE    = 2'd3
   } op_type;

   typedef enum logic [3:0] {
      STAT_TRACKED    = 4'd0,
      STAT_FULL       = 4'd1,
      STAT_ALLOC_NULL = 4'd2,
      STAT_RE_UPDATED = 4'd3,
      STAT_RE_FAILED  = 4'd4,
      STAT_RE_NEW     = 4'd5,
      STAT_FREED      = 4'd6,
      STAT_DOUBLE     = 4'd7,
      STAT_UNTRACKED  = 4'd8
   } status_type;

   typedef enum logic [1:0] {
      FSM_IDLE   = 2'd0,
      FSM_SEARCH = 2'd1,
      FSM_APPLY  = 2'd2
   } fsm_type;

   typedef enum logic [1:0] {
      WR_FILL = 2'd0,
      WR_MOVE = 2'd1,
      WR_FREE = 2'd2
   } wr_kind_type;

   typedef struct packed {
      logic [31:0] addr;
      cnt_type     slots_used;
   } rec_key_type;

   typedef struct packed {
      logic        live_hit;
      idx_type     live_idx;
      logic [23:0] live_size;
      logic        free_hit;
      idx_type     free_idx;
      logic        dbl_hit;
      idx_type     dbl_idx;
      logic [23:0] dbl_size;
      logic [31:0] dbl_caller;
   } rec_token_type;

   typedef struct packed {
      logic        en;
      wr_kind_type kind;
      idx_type     idx;
      logic [31:0] old_addr;
      logic [31:0] new_addr;
      logic [23:0] size;
      logic [31:0] caller;
   } rec_wr_type;

   typedef struct packed {
      logic [31:0] caller;
      cnt_type     used;
   } hot_key_type;

   typedef struct packed {
      logic        hit;
      idx_type     idx;
      logic [31:0] count;
   } hot_token_type;

   typedef struct packed {
      logic        en;
      logic        fresh;
      idx_type     idx;
      logic [31:0] caller;
   } hot_wr_type;

endpackage

[rtl/hat_if.sv]
// Interfaces: event request channel and result channel.
interface hat_req_if;
   logic        valid;
   logic        ready;
   logic [1:0]  op;
   logic [31:0] old_address;
   logic [31:0] new_address;
   logic [23:0] req_size;
   logic [31:0] caller;

   modport source (output valid, op, old_address, new_address, req_size, caller,
                   input ready);
   modport sink   (input valid, op, old_address, new_address, req_size, caller,
                   output ready);
endinterface

interface hat_rsp_if;
   logic        valid;
   logic        ready;
   logic [3:0]  status;
   logic [4:0]  slot_index;
   logic [23:0] found_size;
   logic [31:0] found_caller;
   logic [31:0] caller_allocations;
   logic [31:0] total_allocated;
   logic [31:0] total_freed;
   logic [5:0]  live_count;
   logic [23:0] largest_seen;
   logic [31:0] realloc_total;
   logic [31:0] realloc_failed;
   logic [31:0] realloc_moved;

   modport source (output valid, status, slot_index, found_size, found_caller,
                   caller_allocations, total_allocated, total_freed, live_count,
                   largest_seen, realloc_total, realloc_failed, realloc_moved,
                   input ready);
   modport sink   (input valid, status, slot_index, found_size, found_caller,
                   caller_allocations, total_allocated, total_freed, live_count,
                   largest_seen, realloc_total, realloc_failed, realloc_moved,
                   output ready);
endinterface

[rtl/heap_allocation_tracker_top.sv]
// Top level: heap event tracker with a row of record cells and a row of hotspot cells.
//
// Each accepted event (alloc, realloc, free) is answered by one result transfer carrying
// the outcome and the running statistics; an event with op code 3 is accepted and
// dropped with no result. An event is captured on its transfer; then the search token
// walks the row of record cells and, alongside, the row of hotspot cells, through one
// register per cell, and the apply step writes the cells and loads the result
// register, after which the block is ready again. The result register stands apart
// from the input side, so a new event may be taken while the previous result still
// waits; the apply step holds only if that register is still occupied.
// RECORDS may range from 1 to 1024. No clearing pass is needed after reset.
module heap_allocation_tracker_top
   import hat_pkg::*;
#(
   parameter int unsigned RECORDS = 32
) (
   input  logic      clock,
   input  logic      reset,
   hat_req_if.sink   req_if,
   hat_rsp_if.source rsp_if
);

   // ---------------------------------------------------------------- state
   fsm_type     state_ff, state_in;
   cnt_type     cnt_ff;
   op_type      op_ff;
   logic [31:0] old_ff, new_ff, caller_ff;
   logic [23:0] size_ff;

   cnt_type     slots_used_ff, slots_used_in;
   cnt_type     hot_used_ff, hot_used_in;
   logic [31:0] alloc_ff, alloc_in;
   logic [31:0] freed_ff, freed_in;
   logic [5:0]  live_ff, live_in;
   logic [23:0] largest_ff, largest_in;
   logic [31:0] calls_ff, calls_in;
   logic [31:0] fails_ff, fails_in;
   logic [31:0] moves_ff, moves_in;

   // result register
   logic        rsp_valid_ff;
   status_type  status_ff, status_in;
   logic [4:0]  slot_ff, slot_in;
   logic [23:0] fsize_ff, fsize_in;
   logic [31:0] fcaller_ff, fcaller_in;
   logic [31:0] hot_ff, hot_in;

   logic        accept, go, req_ready;
   logic        pick_hit, do_fill, do_hot;
   idx_type     pick_idx, slot_idx;

   rec_key_type   rec_key;
   hot_key_type   hot_key;
   rec_wr_type    rec_wr, rec_wr_d;
   hot_wr_type    hot_wr, hot_wr_d;
   rec_token_type rec_tok [RECORDS+1];
   hot_token_type hot_tok [RECORDS+1];
   rec_token_type rec_res;
   hot_token_type hot_res;

   // ---------------------------------------------------------------- cell rows
   assign rec_key = '{addr: old_ff, slots_used: slots_used_ff};
   assign hot_key = '{caller: caller_ff, used: hot_used_ff};
   assign rec_tok[0] = '0;
   assign hot_tok[0] = '0;

   for (genvar g = 0; g < RECORDS; g++) begin : g_cells
      hat_rec_cell #(.INDEX(g)) u_rec (
         .clock  (clock),
         .reset  (reset),
         .key    (rec_key),
         .wr     (rec_wr),
         .tok_in (rec_tok[g]),
         .tok_out(rec_tok[g+1])
      );
      hat_hot_cell #(.INDEX(g)) u_hot (
         .clock  (clock),
         .reset  (reset),
         .key    (hot_key),
         .wr     (hot_wr),
         .tok_in (hot_tok[g]),
         .tok_out(hot_tok[g+1])
      );
   end

   assign rec_res = rec_tok[RECORDS];
   assign hot_res = hot_tok[RECORDS];

   // ---------------------------------------------------------------- control
   assign accept = req_if.valid && req_ready;
   assign go     = (state_ff == FSM_APPLY) && (!rsp_valid_ff || rsp_if.ready);

   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         FSM_IDLE: begin
            if (accept && (op_type'(req_if.op) != OP_NONE)) state_in = FSM_SEARCH;
         end
         FSM_SEARCH: begin
            if (cnt_ff == cnt_type'(RECORDS - 1)) state_in = FSM_APPLY;
         end
         FSM_APPLY: begin
            if (go) state_in = FSM_IDLE;
         end
         default: state_in = FSM_IDLE;
      endcase
   end

   always_comb begin
      req_ready = 1'b0;
      rec_wr    = rec_wr_d;
      hot_wr    = hot_wr_d;
      unique case (state_ff)
         FSM_IDLE:   req_ready = 1'b1;
         FSM_SEARCH: ;
         FSM_APPLY:  ;
         default:    ;
      endcase
      rec_wr.en = rec_wr_d.en && go;
      hot_wr.en = hot_wr_d.en && go;
   end

   assign req_if.ready = req_ready;

   // ---------------------------------------------------------------- decision
   // First freed slot among those used, else the next fresh one.
   assign pick_hit = rec_res.free_hit || (slots_used_ff < cnt_type'(RECORDS));
   assign pick_idx = rec_res.free_hit ? rec_res.free_idx : idx_type'(slots_used_ff);

   always_comb begin
      status_in     = STAT_UNTRACKED;
      slot_idx      = '0;
      fsize_in      = '0;
      fcaller_in    = '0;
      hot_in        = '0;
      slots_used_in = slots_used_ff;
      hot_used_in   = hot_used_ff;
      alloc_in      = alloc_ff;
      freed_in      = freed_ff;
      live_in       = live_ff;
      largest_in    = largest_ff;
      calls_in      = calls_ff;
      fails_in      = fails_ff;
      moves_in      = moves_ff;
      do_fill       = 1'b0;
      do_hot        = 1'b0;
      rec_wr_d      = '{en: 1'b0, kind: WR_FILL, idx: '0, old_addr: old_ff,
                        new_addr: new_ff, size: size_ff, caller: caller_ff};
      hot_wr_d      = '{en: 1'b0, fresh: 1'b0, idx: '0, caller: caller_ff};

      unique case (op_ff)
         OP_ALLOC: begin
            if (!pick_hit) begin
               status_in = STAT_FULL;
            end else if (new_ff == 32'd0) begin
               status_in = STAT_ALLOC_NULL;
            end else begin
               do_fill   = 1'b1;
               status_in = STAT_TRACKED;
               slot_idx  = pick_idx;
            end
         end
         OP_REALLOC: begin
            calls_in = calls_ff + 32'd1;
            if (new_ff == 32'd0) begin
               fails_in  = fails_ff + 32'd1;
               status_in = STAT_RE_FAILED;
            end else if (rec_res.live_hit) begin
               // tracked block: resize in place, caller of first alloc kept
               if (new_ff != old_ff) moves_in = moves_ff + 32'd1;
               if (size_ff > rec_res.live_size)
                  alloc_in = alloc_ff + 32'(size_ff - rec_res.live_size);
               else if (size_ff < rec_res.live_size)
                  freed_in = freed_ff + 32'(rec_res.live_size - size_ff);
               if (size_ff > largest_ff) largest_in = size_ff;
               rec_wr_d.en   = 1'b1;
               rec_wr_d.kind = WR_MOVE;
               rec_wr_d.idx  = rec_res.live_idx;
               do_hot        = 1'b1;
               status_in     = STAT_RE_UPDATED;
               slot_idx      = rec_res.live_idx;
            end else if (!pick_hit) begin
               status_in = STAT_FULL;
            end else begin
               do_fill   = 1'b1;
               status_in = STAT_RE_NEW;
               slot_idx  = pick_idx;
            end
         end
         OP_FREE: begin
            if (rec_res.live_hit) begin
               rec_wr_d.en   = 1'b1;
               rec_wr_d.kind = WR_FREE;
               rec_wr_d.idx  = rec_res.live_idx;
               freed_in      = freed_ff + 32'(rec_res.live_size);
               if (live_ff != 6'd0) live_in = live_ff - 6'd1;
               status_in     = STAT_FREED;
               slot_idx      = rec_res.live_idx;
               fsize_in      = rec_res.live_size;
            end else if (rec_res.dbl_hit) begin
               // null never matches in the cells, so this is a genuine double free
               status_in  = STAT_DOUBLE;
               slot_idx   = rec_res.dbl_idx;
               fsize_in   = rec_res.dbl_size;
               fcaller_in = rec_res.dbl_caller;
            end
         end
         default: ;
      endcase

      if (do_fill) begin
         rec_wr_d.en   = 1'b1;
         rec_wr_d.kind = WR_FILL;
         rec_wr_d.idx  = pick_idx;
         alloc_in      = alloc_ff + 32'(size_ff);
         if (live_ff != 6'd63) live_in = live_ff + 6'd1;
         if (size_ff > largest_ff) largest_in = size_ff;
         if (!rec_res.free_hit) slots_used_in = slots_used_ff + cnt_type'(1);
         do_hot = 1'b1;
      end

      if (do_hot) begin
         if (hot_res.hit) begin
            hot_wr_d.en  = 1'b1;
            hot_wr_d.idx = hot_res.idx;
            hot_in       = hot_res.count + 32'd1;
         end else if (hot_used_ff < cnt_type'(RECORDS)) begin
            hot_wr_d.en    = 1'b1;
            hot_wr_d.fresh = 1'b1;
            hot_wr_d.idx   = idx_type'(hot_used_ff);
            hot_in         = 32'd1;
            hot_used_in    = hot_used_ff + cnt_type'(1);
         end
      end

      slot_in = 5'(slot_idx);
   end

   // ---------------------------------------------------------------- registers
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= FSM_IDLE;
         cnt_ff        <= '0;
         slots_used_ff <= '0;
         hot_used_ff   <= '0;
         alloc_ff      <= '0;
         freed_ff      <= '0;
         live_ff       <= '0;
         largest_ff    <= '0;
         calls_ff      <= '0;
         fails_ff      <= '0;
         moves_ff      <= '0;
         rsp_valid_ff  <= 1'b0;
      end else begin
         state_ff <= state_in;
         if (state_ff == FSM_SEARCH) cnt_ff <= cnt_ff + cnt_type'(1);
         else                        cnt_ff <= '0;
         if (go) begin
            slots_used_ff <= slots_used_in;
            hot_used_ff   <= hot_used_in;
            alloc_ff      <= alloc_in;
            freed_ff      <= freed_in;
            live_ff       <= live_in;
            largest_ff    <= largest_in;
            calls_ff      <= calls_in;
            fails_ff      <= fails_in;
            moves_ff      <= moves_in;
            rsp_valid_ff  <= 1'b1;
         end else if (rsp_if.ready) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   // event capture and result payload
   always_ff @(posedge clock) begin
      if (accept) begin
         op_ff     <= op_type'(req_if.op);
         old_ff    <= req_if.old_address;
         new_ff    <= req_if.new_address;
         size_ff   <= req_if.req_size;
         caller_ff <= req_if.caller;
      end
      if (go) begin
         status_ff  <= status_in;
         slot_ff    <= slot_in;
         fsize_ff   <= fsize_in;
         fcaller_ff <= fcaller_in;
         hot_ff     <= hot_in;
      end
   end

   // ---------------------------------------------------------------- result port
   // Statistics are read from the live counters; they change only on the next
   // apply, which cannot happen while a result waits.
   assign rsp_if.valid              = rsp_valid_ff;
   assign rsp_if.status             = status_ff;
   assign rsp_if.slot_index         = slot_ff;
   assign rsp_if.found_size         = fsize_ff;
   assign rsp_if.found_caller       = fcaller_ff;
   assign rsp_if.caller_allocations = hot_ff;
   assign rsp_if.total_allocated    = alloc_ff;
   assign rsp_if.total_freed        = freed_ff;
   assign rsp_if.live_count         = live_ff;
   assign rsp_if.largest_seen       = largest_ff;
   assign rsp_if.realloc_total      = calls_ff;
   assign rsp_if.realloc_failed     = fails_ff;
   assign rsp_if.realloc_moved      = moves_ff;

endmodule

[rtl/hat_rec_cell.sv]
// One allocation record cell: holds a record, folds its match into the search token.
module hat_rec_cell
   import hat_pkg::*;
#(
   parameter int unsigned INDEX = 0
) (
   input  logic          clock,
   input  logic          reset,
   input  rec_key_type   key,
   input  rec_wr_type    wr,
   input  rec_token_type tok_in,
   output rec_token_type tok_out
);

   logic [31:0]   live_addr_ff;
   logic [31:0]   freed_addr_ff;
   logic [23:0]   size_ff;
   logic          is_freed_ff;
   logic [31:0]   caller_ff;
   rec_token_type tok_ff, tok_in_next;
   logic          live_m, free_m, dbl_m, sel;

   assign sel    = wr.en && (wr.idx == idx_type'(INDEX));
   assign live_m = (key.addr != 32'd0) && (live_addr_ff == key.addr) && !is_freed_ff;
   assign free_m = is_freed_ff && (live_addr_ff == 32'd0)
                   && (cnt_type'(INDEX) < key.slots_used);
   assign dbl_m  = is_freed_ff && (key.addr != 32'd0) && (freed_addr_ff == key.addr);

   // first hit along the row wins
   always_comb begin
      tok_in_next = tok_in;
      if (!tok_in.live_hit && live_m) begin
         tok_in_next.live_hit  = 1'b1;
         tok_in_next.live_idx  = idx_type'(INDEX);
         tok_in_next.live_size = size_ff;
      end
      if (!tok_in.free_hit && free_m) begin
         tok_in_next.free_hit = 1'b1;
         tok_in_next.free_idx = idx_type'(INDEX);
      end
      if (!tok_in.dbl_hit && dbl_m) begin
         tok_in_next.dbl_hit    = 1'b1;
         tok_in_next.dbl_idx    = idx_type'(INDEX);
         tok_in_next.dbl_size   = size_ff;
         tok_in_next.dbl_caller = caller_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         tok_ff <= '0;
      end else begin
         tok_ff <= tok_in_next;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         live_addr_ff <= '0;
         is_freed_ff  <= 1'b0;
      end else if (sel) begin
         unique case (wr.kind)
            WR_FILL: begin
               live_addr_ff <= wr.new_addr;
               is_freed_ff  <= 1'b0;
            end
            WR_MOVE: begin
               live_addr_ff <= wr.new_addr;
               is_freed_ff  <= 1'b0;
            end
            WR_FREE: begin
               live_addr_ff <= 32'd0;
               is_freed_ff  <= 1'b1;
            end
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (sel) begin
         unique case (wr.kind)
            WR_FILL: begin
               freed_addr_ff <= 32'd0;
               size_ff       <= wr.size;
               caller_ff     <= wr.caller;
            end
            WR_MOVE: begin
               freed_addr_ff <= 32'd0;
               size_ff       <= wr.size;
            end
            WR_FREE: freed_addr_ff <= wr.old_addr;
            default: ;
         endcase
      end
   end

   assign tok_out = tok_ff;

endmodule

[rtl/hat_hot_cell.sv]
// One hotspot cell: caller and its allocation count, folded into the hotspot token.
module hat_hot_cell
   import hat_pkg::*;
#(
   parameter int unsigned INDEX = 0
) (
   input  logic          clock,
   input  logic          reset,
   input  hot_key_type   key,
   input  hot_wr_type    wr,
   input  hot_token_type tok_in,
   output hot_token_type tok_out
);

   logic [31:0]   caller_ff;
   logic [31:0]   count_ff;
   hot_token_type tok_ff, tok_in_next;
   logic          match, sel;

   assign sel   = wr.en && (wr.idx == idx_type'(INDEX));
   assign match = (cnt_type'(INDEX) < key.used) && (caller_ff == key.caller);

   always_comb begin
      tok_in_next = tok_in;
      if (!tok_in.hit && match) begin
         tok_in_next.hit   = 1'b1;
         tok_in_next.idx   = idx_type'(INDEX);
         tok_in_next.count = count_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         tok_ff <= '0;
      end else begin
         tok_ff <= tok_in_next;
      end
   end

   always_ff @(posedge clock) begin
      if (sel) begin
         if (wr.fresh) begin
            caller_ff <= wr.caller;
            count_ff  <= 32'd1;
         end else begin
            count_ff <= count_ff + 32'd1;
         end
      end
   end

   assign tok_out = tok_ff;

endmodule

[rtl/hat_checker.sv]
// Checker: port-level properties of the heap allocation tracker, bound to the top level.
module hat_checker
   import hat_pkg::*;
#(
   parameter int unsigned RECORDS = 32
) (
   input logic        clock,
   input logic        reset,
   input logic        req_valid,
   input logic        req_ready,
   input logic [1:0]  req_op,
   input logic        rsp_valid,
   input logic        rsp_ready,
   input logic [3:0]  rsp_status,
   input logic [5:0]  rsp_live_count,
   input logic [31:0] rsp_total_allocated
);

   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid)
      else $error("result dropped before transfer");

   a_rsp_stable: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> $stable(rsp_status) && $stable(rsp_total_allocated))
      else $error("stalled result changed");

   a_busy_after_event: assert property (@(posedge clock) disable iff (reset)
      req_valid && req_ready && (req_op != OP_NONE) |=> !req_ready)
      else $error("new event taken while one is in search");

   a_no_rsp_after_reset: assert property (@(posedge clock)
      reset |=> !rsp_valid)
      else $error("result valid right after reset");

   a_rsp_range: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> (rsp_status <= STAT_UNTRACKED)
                    && (32'(rsp_live_count) <= RECORDS || rsp_live_count == 6'd63))
      else $error("result status or live count out of range");

endmodule

bind heap_allocation_tracker_top hat_checker #(.RECORDS(RECORDS)) u_hat_checker (
   .clock              (clock),
   .reset              (reset),
   .req_valid          (req_if.valid),
   .req_ready          (req_if.ready),
   .req_op             (req_if.op),
   .rsp_valid          (rsp_if.valid),
   .rsp_ready          (rsp_if.ready),
   .rsp_status         (rsp_if.status),
   .rsp_live_count     (rsp_if.live_count),
   .rsp_total_allocated(rsp_if.total_allocated)
);
